@@ src/nearest_neighbor_fit_downscaler_top_assert.svh @@
// ----------------------------------------------------------------------------
// nearest neighbor fit downscaler assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_FIT_DOWNSCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_FIT_DOWNSCALER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is held
`define NNFD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("nnfd assertion failed");
// clocked check, also active during reset
`define NNFD_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("nnfd assertion failed");
`else
`define NNFD_ASSERT(label, clk, rstn, prop)
`define NNFD_ASSERT_NR(label, clk, prop)
`endif

`endif

@@ src/nnfd_pkg.sv @@
// ----------------------------------------------------------------------------
// nnfd_pkg
// shared widths, codes, command and status types for the downscaler
// ----------------------------------------------------------------------------
package nnfd_pkg;

    localparam int MAX_DIM      = 4096;
    localparam int MAX_CHANNELS = 4;

    localparam int DIM_W      = 13;           // holds 0..MAX_DIM
    localparam int COORD_W    = 12;           // output coordinates
    localparam int CH_W       = 3;            // holds 0..MAX_CHANNELS
    localparam int CHAN_IDX_W = 2;
    localparam int SAMPLE_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 2 * DIM_W;    // size products and dividends
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam int OUT_FIELDS_W = SAMPLE_W + 2 * COORD_W + CHAN_IDX_W + 2 * DIM_W;
    localparam int M_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_NUM_CHAN   = 3'd2,
        CFG_BOX_WIDTH  = 3'd3,
        CFG_BOX_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_RUN,
        ST_MUL,
        ST_SIZE,
        ST_DIM_WAIT,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_ROW_GO,
        ST_ROW_WAIT,
        ST_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic start_frame;  // latch geometry and held sample, clear counters
        logic mul;          // register the aspect products
        logic size;         // pick output size, start divide if needed
        logic dim_store;    // capture divided dimension
        logic col_start;
        logic col_store;
        logic row_start;
        logic row_store;
        logic step_in;      // process the sample on the input port
        logic step_hold;    // process the held frame start sample
    } ctl_cmd_t;

    typedef struct packed {
        logic fits;
        logic dw_zero;
        logic dh_zero;
        logic out_free;
        logic div_busy;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [DIM_W-1:0]      out_height;
        logic [DIM_W-1:0]      out_width;
        logic [CHAN_IDX_W-1:0] chan_index;
        logic [COORD_W-1:0]    out_row;
        logic [COORD_W-1:0]    out_col;
        logic [SAMPLE_W-1:0]   pixel_sample;
    } out_fields_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CH_W-1:0] clamp_chan(input logic [CH_W-1:0] v);
        logic [CH_W-1:0] r;
        if (v == '0) begin
            r = CH_W'(1);
        end else if (v > CH_W'(MAX_CHANNELS)) begin
            r = CH_W'(MAX_CHANNELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ src/nnfd_div.sv @@
// ----------------------------------------------------------------------------
// nnfd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnfd_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [nnfd_pkg::PROD_W-1:0]     dividend,
    input  logic [nnfd_pkg::DIM_W-1:0]      divisor,
    output logic                            busy,
    output logic                            done,
    output logic [nnfd_pkg::PROD_W-1:0]     quot,
    output logic [nnfd_pkg::DIM_W-1:0]      rem
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [nnfd_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [nnfd_pkg::PROD_W-1:0]       quot_reg;
    logic [nnfd_pkg::DIM_W-1:0]        rem_reg;
    logic [nnfd_pkg::DIM_W-1:0]        dvs_reg;

    logic [nnfd_pkg::DIM_W:0]          trial;
    logic                              ge;
    logic [nnfd_pkg::DIM_W-1:0]        rem_next;
    logic [nnfd_pkg::PROD_W-1:0]       quot_next;

    always_comb begin
        trial     = {rem_reg, quot_reg[nnfd_pkg::PROD_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        rem_next  = ge ? nnfd_pkg::DIM_W'(trial - {1'b0, dvs_reg})
                       : trial[nnfd_pkg::DIM_W-1:0];
        quot_next = {quot_reg[nnfd_pkg::PROD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= nnfd_pkg::DIV_CNT_W'(nnfd_pkg::PROD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == nnfd_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

@@ src/nnfd_dp.sv @@
// ----------------------------------------------------------------------------
// nnfd_dp
// registers, frame geometry, position tracking and output register
// ----------------------------------------------------------------------------
module nnfd_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [nnfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nnfd_pkg::DIM_W-1:0]          cfg_data,
    input  logic [nnfd_pkg::SAMPLE_W-1:0]       s_sample,
    input  nnfd_pkg::ctl_cmd_t                  cmd,
    output nnfd_pkg::dp_status_t                sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [nnfd_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    localparam int DW = nnfd_pkg::DIM_W;
    localparam int CW = nnfd_pkg::COORD_W;
    localparam int HW = nnfd_pkg::CH_W;
    localparam int PW = nnfd_pkg::PROD_W;

    // configuration
    logic [DW-1:0] src_w_cfg_reg, src_h_cfg_reg, box_w_cfg_reg, box_h_cfg_reg;
    logic [HW-1:0] nch_cfg_reg;

    // geometry latched at frame start
    logic [DW-1:0] frame_w_reg, frame_h_reg, box_w_reg, box_h_reg;
    logic [HW-1:0] frame_c_reg;
    logic [nnfd_pkg::SAMPLE_W-1:0] hold_sample_reg;
    logic [PW-1:0] prod_a_reg, prod_b_reg;
    logic          dim_to_w_reg;

    logic [DW-1:0] dest_w_reg, dest_h_reg;
    logic [DW-1:0] col_quot_reg, row_quot_reg;
    logic [CW-1:0] col_rem_reg, row_rem_reg;

    // position tracking
    logic [CW-1:0]                   src_col_reg;
    logic [DW-1:0]                   src_row_reg;
    logic [nnfd_pkg::CHAN_IDX_W-1:0] chan_reg;
    logic [DW-1:0]                   next_col_reg, next_row_reg;
    logic [CW-1:0]                   col_acc_reg, row_acc_reg;
    logic [DW-1:0]                   dcol_reg, drow_reg;

    logic                            out_valid_reg;
    nnfd_pkg::out_fields_t           out_data_reg;
    logic                            out_last_reg;

    // divider hookup
    logic          div_start, div_busy, div_done;
    logic [PW-1:0] div_dividend, div_quot;
    logic [DW-1:0] div_divisor, div_rem;

    logic          fits, wide_h;
    logic [PW-1:0] prod_a_full, prod_b_full;

    // per sample
    logic          step_en, active, row_sel, col_sel, emit, last;
    logic          chan_wrap, col_wrap, col_carry, row_carry;
    logic [HW-1:0] chan_inc;
    logic [DW-1:0] src_col_inc, src_row_inc;
    logic [DW-1:0] col_acc_sum, row_acc_sum;
    logic [DW-1:0] next_col_next, next_row_next;
    logic [CW-1:0] col_acc_next, row_acc_next;
    logic [nnfd_pkg::SAMPLE_W-1:0] step_sample;
    nnfd_pkg::out_fields_t out_data_next;

    always_comb begin
        prod_a_full = {{DW{1'b0}}, box_w_reg} * {{DW{1'b0}}, frame_h_reg};
        prod_b_full = {{DW{1'b0}}, box_h_reg} * {{DW{1'b0}}, frame_w_reg};
        fits   = !(frame_w_reg > box_w_reg || frame_h_reg > box_h_reg);
        wide_h = prod_a_reg > prod_b_reg;

        div_start = (cmd.size && !fits) || cmd.col_start || cmd.row_start;
        if (cmd.col_start) begin
            div_dividend = PW'(frame_w_reg);
            div_divisor  = dest_w_reg;
        end else if (cmd.row_start) begin
            div_dividend = PW'(frame_h_reg);
            div_divisor  = dest_h_reg;
        end else if (wide_h) begin
            div_dividend = prod_b_reg;
            div_divisor  = frame_h_reg;
        end else begin
            div_dividend = prod_a_reg;
            div_divisor  = frame_w_reg;
        end
    end

    nnfd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb begin
        step_en     = cmd.step_in || cmd.step_hold;
        step_sample = cmd.step_hold ? hold_sample_reg : s_sample;

        active  = (dest_w_reg != '0) && (dest_h_reg != '0) && (src_row_reg < frame_h_reg);
        row_sel = (drow_reg < dest_h_reg) && (src_row_reg == next_row_reg);
        col_sel = (dcol_reg < dest_w_reg) && ({1'b0, src_col_reg} == next_col_reg);
        emit    = active && row_sel && col_sel;

        chan_inc  = {1'b0, chan_reg} + 1'b1;
        chan_wrap = chan_inc >= frame_c_reg;
        last      = (drow_reg + 1'b1 == dest_h_reg) && (dcol_reg + 1'b1 == dest_w_reg)
                    && (chan_inc == frame_c_reg);

        col_acc_sum   = {1'b0, col_acc_reg} + {1'b0, col_rem_reg};
        col_carry     = col_acc_sum >= dest_w_reg;
        col_acc_next  = col_carry ? CW'(col_acc_sum - dest_w_reg) : col_acc_sum[CW-1:0];
        next_col_next = next_col_reg + col_quot_reg + {{(DW-1){1'b0}}, col_carry};

        row_acc_sum   = {1'b0, row_acc_reg} + {1'b0, row_rem_reg};
        row_carry     = row_acc_sum >= dest_h_reg;
        row_acc_next  = row_carry ? CW'(row_acc_sum - dest_h_reg) : row_acc_sum[CW-1:0];
        next_row_next = next_row_reg + row_quot_reg + {{(DW-1){1'b0}}, row_carry};

        src_col_inc = {1'b0, src_col_reg} + 1'b1;
        col_wrap    = src_col_inc >= frame_w_reg;
        src_row_inc = src_row_reg + 1'b1;

        out_data_next.pixel_sample = step_sample;
        out_data_next.out_col      = dcol_reg[CW-1:0];
        out_data_next.out_row      = drow_reg[CW-1:0];
        out_data_next.chan_index   = chan_reg;
        out_data_next.out_width    = dest_w_reg;
        out_data_next.out_height   = dest_h_reg;
    end

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_cfg_reg <= DW'(1);
            src_h_cfg_reg <= DW'(1);
            nch_cfg_reg   <= HW'(3);
            box_w_cfg_reg <= DW'(200);
            box_h_cfg_reg <= DW'(150);
        end else if (cfg_we) begin
            case (cfg_index)
                nnfd_pkg::CFG_SRC_WIDTH:  src_w_cfg_reg <= cfg_data;
                nnfd_pkg::CFG_SRC_HEIGHT: src_h_cfg_reg <= cfg_data;
                nnfd_pkg::CFG_NUM_CHAN:   nch_cfg_reg   <= cfg_data[HW-1:0];
                nnfd_pkg::CFG_BOX_WIDTH:  box_w_cfg_reg <= cfg_data;
                nnfd_pkg::CFG_BOX_HEIGHT: box_h_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // geometry, steps and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg  <= '0;
            frame_h_reg  <= '0;
            frame_c_reg  <= '0;
            box_w_reg    <= '0;
            box_h_reg    <= '0;
            dim_to_w_reg <= 1'b0;
            dest_w_reg   <= '0;
            dest_h_reg   <= '0;
            col_quot_reg <= '0;
            col_rem_reg  <= '0;
            row_quot_reg <= '0;
            row_rem_reg  <= '0;
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            chan_reg     <= '0;
            next_col_reg <= '0;
            col_acc_reg  <= '0;
            next_row_reg <= '0;
            row_acc_reg  <= '0;
            dcol_reg     <= '0;
            drow_reg     <= '0;
        end else begin
            if (cmd.start_frame) begin
                frame_w_reg  <= nnfd_pkg::clamp_dim(src_w_cfg_reg);
                frame_h_reg  <= nnfd_pkg::clamp_dim(src_h_cfg_reg);
                frame_c_reg  <= nnfd_pkg::clamp_chan(nch_cfg_reg);
                box_w_reg    <= nnfd_pkg::clamp_dim(box_w_cfg_reg);
                box_h_reg    <= nnfd_pkg::clamp_dim(box_h_cfg_reg);
                dest_w_reg   <= '0;
                dest_h_reg   <= '0;
                col_quot_reg <= '0;
                col_rem_reg  <= '0;
                row_quot_reg <= '0;
                row_rem_reg  <= '0;
                src_col_reg  <= '0;
                src_row_reg  <= '0;
                chan_reg     <= '0;
                next_col_reg <= '0;
                col_acc_reg  <= '0;
                next_row_reg <= '0;
                row_acc_reg  <= '0;
                dcol_reg     <= '0;
                drow_reg     <= '0;
            end
            if (cmd.size) begin
                if (fits) begin
                    dest_w_reg <= frame_w_reg;
                    dest_h_reg <= frame_h_reg;
                end else if (wide_h) begin
                    dest_h_reg   <= box_h_reg;
                    dim_to_w_reg <= 1'b1;
                end else begin
                    dest_w_reg   <= box_w_reg;
                    dim_to_w_reg <= 1'b0;
                end
            end
            if (cmd.dim_store) begin
                if (dim_to_w_reg) begin
                    dest_w_reg <= div_quot[DW-1:0];
                end else begin
                    dest_h_reg <= div_quot[DW-1:0];
                end
            end
            if (cmd.col_store) begin
                col_quot_reg <= div_quot[DW-1:0];
                col_rem_reg  <= div_rem[CW-1:0];
            end
            if (cmd.row_store) begin
                row_quot_reg <= div_quot[DW-1:0];
                row_rem_reg  <= div_rem[CW-1:0];
            end
            if (step_en && active) begin
                chan_reg <= chan_wrap ? '0 : chan_inc[nnfd_pkg::CHAN_IDX_W-1:0];
                if (chan_wrap) begin
                    if (col_wrap) begin
                        // new source row: restart column selection
                        src_col_reg  <= '0;
                        next_col_reg <= '0;
                        col_acc_reg  <= '0;
                        dcol_reg     <= '0;
                        if (row_sel) begin
                            next_row_reg <= next_row_next;
                            row_acc_reg  <= row_acc_next;
                            drow_reg     <= drow_reg + 1'b1;
                        end
                        src_row_reg <= src_row_inc;
                    end else begin
                        if (col_sel) begin
                            next_col_reg <= next_col_next;
                            col_acc_reg  <= col_acc_next;
                            dcol_reg     <= dcol_reg + 1'b1;
                        end
                        src_col_reg <= src_col_inc[CW-1:0];
                    end
                end
            end
        end
    end

    // payload held for the frame
    always_ff @(posedge aclk) begin
        if (cmd.start_frame) begin
            hold_sample_reg <= s_sample;
        end
        if (cmd.mul) begin
            prod_a_reg <= prod_a_full;
            prod_b_reg <= prod_b_full;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && emit) begin
            out_data_reg <= out_data_next;
            out_last_reg <= last;
        end
    end

    assign sts.fits     = fits;
    assign sts.dw_zero  = dest_w_reg == '0;
    assign sts.dh_zero  = dest_h_reg == '0;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(nnfd_pkg::M_DATA_W - nnfd_pkg::OUT_FIELDS_W){1'b0}}, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ src/nnfd_ctl.sv @@
// ----------------------------------------------------------------------------
// nnfd_ctl
// sequencer for frame setup and sample acceptance
// ----------------------------------------------------------------------------
`include "nearest_neighbor_fit_downscaler_top_assert.svh"

module nnfd_ctl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  frame_start,
    output logic                  s_tready,
    input  nnfd_pkg::dp_status_t  sts,
    output nnfd_pkg::ctl_cmd_t    cmd
);

    nnfd_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nnfd_pkg::ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            nnfd_pkg::ST_RUN: begin
                s_tready = sts.out_free;
                if (s_tvalid && sts.out_free) begin
                    if (frame_start) begin
                        cmd.start_frame = 1'b1;
                        state_next      = nnfd_pkg::ST_MUL;
                    end else begin
                        cmd.step_in = 1'b1;
                    end
                end
            end
            nnfd_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = nnfd_pkg::ST_SIZE;
            end
            nnfd_pkg::ST_SIZE: begin
                cmd.size   = 1'b1;
                state_next = sts.fits ? nnfd_pkg::ST_COL_GO : nnfd_pkg::ST_DIM_WAIT;
            end
            nnfd_pkg::ST_DIM_WAIT: begin
                if (sts.div_done) begin
                    cmd.dim_store = 1'b1;
                    state_next    = nnfd_pkg::ST_COL_GO;
                end
            end
            nnfd_pkg::ST_COL_GO: begin
                if (sts.dw_zero) begin
                    state_next = nnfd_pkg::ST_ROW_GO;
                end else begin
                    cmd.col_start = 1'b1;
                    state_next    = nnfd_pkg::ST_COL_WAIT;
                end
            end
            nnfd_pkg::ST_COL_WAIT: begin
                if (sts.div_done) begin
                    cmd.col_store = 1'b1;
                    state_next    = nnfd_pkg::ST_ROW_GO;
                end
            end
            nnfd_pkg::ST_ROW_GO: begin
                if (sts.dh_zero) begin
                    state_next = nnfd_pkg::ST_HOLD;
                end else begin
                    cmd.row_start = 1'b1;
                    state_next    = nnfd_pkg::ST_ROW_WAIT;
                end
            end
            nnfd_pkg::ST_ROW_WAIT: begin
                if (sts.div_done) begin
                    cmd.row_store = 1'b1;
                    state_next    = nnfd_pkg::ST_HOLD;
                end
            end
            nnfd_pkg::ST_HOLD: begin
                if (sts.out_free) begin
                    cmd.step_hold = 1'b1;
                    state_next    = nnfd_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = nnfd_pkg::ST_RUN;
            end
        endcase
    end

    // a column or row divide is only launched on an idle divider
    `NNFD_ASSERT(a_div_idle, aclk, aresetn, (cmd.col_start || cmd.row_start) |-> !sts.div_busy)
    // leaving the accept state needs a frame start request
    `NNFD_ASSERT(a_leave_run, aclk, aresetn, (state_reg == nnfd_pkg::ST_RUN && state_next != nnfd_pkg::ST_RUN) |-> (s_tvalid && frame_start))
    // divide results only show up while the sequencer waits for them
    `NNFD_ASSERT(a_done_wait, aclk, aresetn, sts.div_done |-> (state_reg == nnfd_pkg::ST_DIM_WAIT || state_reg == nnfd_pkg::ST_COL_WAIT || state_reg == nnfd_pkg::ST_ROW_WAIT))
    // held sample is processed with the divider at rest
    `NNFD_ASSERT_NR(a_hold_quiet, aclk, (aresetn && state_reg == nnfd_pkg::ST_HOLD) |-> !sts.div_busy)

endmodule

@@ src/nearest_neighbor_fit_downscaler_top.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_fit_downscaler_top
// nearest-neighbor fit of a raster sample stream into a bounding box
// ----------------------------------------------------------------------------
// s_ channel: one channel sample per request, raster order, channels
//   interleaved; s_tuser set on the first sample of a frame
// m_ channel: only the samples the fit keeps, with output position, channel
//   and output size; m_tlast marks the last sample of the output frame
// cfg port: write registers (source size, channels, box size) between frames;
//   they are latched when the next frame start request is taken
// an ordinary sample is taken each cycle s_tready is high; result next cycle
// a frame start request holds s_tready low during frame setup: up to three
//   runs of the shared 26-step divider (size when the source does not fit,
//   column and row steps for a nonzero output size) and five sequencing
//   states, the last of which processes the marked sample
// reset: registers return to their defaults, output size reads zero, and
//   samples are dropped until the first frame start request
// stall: while m_tready is low and a result waits, s_tready is held low
// ----------------------------------------------------------------------------
module nearest_neighbor_fit_downscaler_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input samples
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [nnfd_pkg::SAMPLE_W-1:0]       s_tdata,   // [7:0] sample
    input  logic                                s_tuser,   // [0] frame_start
    // selected samples
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] pixel_sample, [19:8] out_col, [31:20] out_row,
    // [33:32] chan_index, [46:34] out_width, [59:47] out_height, rest zero
    output logic [nnfd_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast,   // frame_last
    // register writes
    input  logic                                cfg_we,
    input  logic [nnfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nnfd_pkg::DIM_W-1:0]          cfg_data
);

    // sequencer to datapath commands and status back
    nnfd_pkg::ctl_cmd_t   cmd;
    nnfd_pkg::dp_status_t sts;

    nnfd_ctl u_ctl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .frame_start (s_tuser),
        .s_tready    (s_tready),
        .sts         (sts),
        .cmd         (cmd)
    );

    // geometry, divider, position tracking and output register
    nnfd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_sample  (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/downscale_checker.sv @@
// ----------------------------------------------------------------------------
// downscale_checker
// watches the sample, result and register ports of the downscaler, keeps its
// own copy of the fit arithmetic and compares every kept sample in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module downscale_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [nnfd_pkg::SAMPLE_W-1:0]     s_tdata,    // [7:0] sample
    input  logic                              s_tuser,    // [0] frame_start
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [nnfd_pkg::M_DATA_W-1:0]     m_tdata,    // packed out_fields_t
    input  logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [nnfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nnfd_pkg::DIM_W-1:0]        cfg_data,
    output int unsigned                       miscompares,
    output int unsigned                       samples_owed
);
    import nnfd_pkg::*;

    typedef struct packed {
        logic        last;
        out_fields_t f;
    } kept_t;

    // register copies
    logic [DIM_W-1:0] src_w_reg, src_h_reg, box_w_reg, box_h_reg;
    logic [CH_W-1:0]  chan_reg;

    // frame geometry latched at frame start
    int unsigned geo_w, geo_h, geo_c;
    int unsigned fit_w, fit_h;
    int unsigned x_quot, x_rem, y_quot, y_rem;

    // position tracking
    int unsigned src_x, src_y, out_x, out_y;
    int unsigned x_pick, x_acc, y_pick, y_acc;
    int unsigned chan_pos;

    kept_t       kept_due[$];
    int unsigned fail_cnt;
    int unsigned results_seen;

    function automatic int unsigned bound_size(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_all();
        src_w_reg = 13'd1;
        src_h_reg = 13'd1;
        chan_reg  = 3'd3;
        box_w_reg = 13'd200;
        box_h_reg = 13'd150;
        geo_w = 0; geo_h = 0; geo_c = 0;
        fit_w = 0; fit_h = 0;
        x_quot = 0; x_rem = 0; y_quot = 0; y_rem = 0;
        src_x = 0; src_y = 0; out_x = 0; out_y = 0;
        x_pick = 0; x_acc = 0; y_pick = 0; y_acc = 0;
        chan_pos = 0;
    endfunction

    // latch geometry, pick the output size and the column and row steps
    function automatic void open_frame();
        int unsigned bw, bh, w, h;
        bw = bound_size(32'(box_w_reg), MAX_DIM);
        bh = bound_size(32'(box_h_reg), MAX_DIM);
        w  = bound_size(32'(src_w_reg), MAX_DIM);
        h  = bound_size(32'(src_h_reg), MAX_DIM);
        geo_w = w;
        geo_h = h;
        geo_c = bound_size(32'(chan_reg), MAX_CHANNELS);
        if (w > bw || h > bh) begin
            if (bw * h > bh * w) begin
                fit_w = (bh * w) / h;
                fit_h = bh;
            end else begin
                fit_w = bw;
                fit_h = (bw * h) / w;
            end
        end else begin
            fit_w = w;
            fit_h = h;
        end
        x_quot = (fit_w != 0) ? w / fit_w : 0;
        x_rem  = (fit_w != 0) ? w % fit_w : 0;
        y_quot = (fit_h != 0) ? h / fit_h : 0;
        y_rem  = (fit_h != 0) ? h % fit_h : 0;
        src_x = 0; src_y = 0; chan_pos = 0;
        x_pick = 0; x_acc = 0; out_x = 0;
        y_pick = 0; y_acc = 0; out_y = 0;
    endfunction

    // advance over one sample, return 1 with the result when it is kept
    function automatic bit fit_sample(input logic [SAMPLE_W-1:0] smp, input logic fs,
                                      output kept_t k);
        bit          row_hit, col_hit, hit;
        int unsigned acc;
        k   = '0;
        hit = 1'b0;
        if (fs) open_frame();
        if (fit_w == 0 || fit_h == 0 || src_y >= geo_h) return 1'b0;

        row_hit = (out_y < fit_h) && (src_y == y_pick);
        col_hit = (out_x < fit_w) && (src_x == x_pick);
        if (row_hit && col_hit) begin
            k.f.pixel_sample = smp;
            k.f.out_col      = COORD_W'(out_x);
            k.f.out_row      = COORD_W'(out_y);
            k.f.chan_index   = CHAN_IDX_W'(chan_pos);
            k.f.out_width    = DIM_W'(fit_w);
            k.f.out_height   = DIM_W'(fit_h);
            k.last = (out_y + 1 == fit_h) && (out_x + 1 == fit_w) &&
                     (chan_pos + 1 == geo_c);
            hit = 1'b1;
        end

        if (chan_pos + 1 >= geo_c) begin
            chan_pos = 0;
            if (col_hit) begin
                acc    = x_acc + x_rem;
                x_pick = x_pick + x_quot;
                if (acc >= fit_w) begin
                    acc    = acc - fit_w;
                    x_pick = x_pick + 1;
                end
                x_acc = acc;
                out_x = out_x + 1;
            end
            if (src_x + 1 >= geo_w) begin
                src_x = 0; x_pick = 0; x_acc = 0; out_x = 0;
                if (row_hit) begin
                    acc    = y_acc + y_rem;
                    y_pick = y_pick + y_quot;
                    if (acc >= fit_h) begin
                        acc    = acc - fit_h;
                        y_pick = y_pick + 1;
                    end
                    y_acc = acc;
                    out_y = out_y + 1;
                end
                src_y = src_y + 1;
            end else begin
                src_x = src_x + 1;
            end
        end else begin
            chan_pos = chan_pos + 1;
        end
        return hit;
    endfunction

    always @(posedge aclk) begin : watch
        kept_t       want;
        kept_t       next_k;
        out_fields_t got;
        bit          bad;
        if (!aresetn) begin
            clear_all();
            kept_due.delete();
            fail_cnt     = 0;
            results_seen = 0;
        end else begin
            // results first: they belong to earlier requests
            if (m_tvalid && m_tready) begin
                got = out_fields_t'(m_tdata[OUT_FIELDS_W-1:0]);
                results_seen++;
                if (kept_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t #%0d unexpected: px %0d col %0d row %0d ch %0d %0dx%0d %0b",
                                 $time, results_seen, got.pixel_sample, got.out_col,
                                 got.out_row, got.chan_index, got.out_width,
                                 got.out_height, m_tlast);
                end else begin
                    want = kept_due.pop_front();
                    bad  = (got.pixel_sample !== want.f.pixel_sample) ||
                           (got.out_col      !== want.f.out_col)      ||
                           (got.out_row      !== want.f.out_row)      ||
                           (got.chan_index   !== want.f.chan_index)   ||
                           (got.out_width    !== want.f.out_width)    ||
                           (got.out_height   !== want.f.out_height)   ||
                           (m_tlast          !== want.last);
                    if (bad) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("%0t #%0d expected: px %0d col %0d row %0d ch %0d %0dx%0d %0b",
                                     $time, results_seen, want.f.pixel_sample,
                                     want.f.out_col, want.f.out_row, want.f.chan_index,
                                     want.f.out_width, want.f.out_height, want.last);
                            $display("%0t #%0d actual:   px %0d col %0d row %0d ch %0d %0dx%0d %0b",
                                     $time, results_seen, got.pixel_sample, got.out_col,
                                     got.out_row, got.chan_index, got.out_width,
                                     got.out_height, m_tlast);
                        end
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_SRC_WIDTH:  src_w_reg = cfg_data;
                    CFG_SRC_HEIGHT: src_h_reg = cfg_data;
                    CFG_NUM_CHAN:   chan_reg  = cfg_data[CH_W-1:0];
                    CFG_BOX_WIDTH:  box_w_reg = cfg_data;
                    CFG_BOX_HEIGHT: box_h_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (fit_sample(s_tdata, s_tuser, next_k)) kept_due.push_back(next_k);
            end
        end
        miscompares  <= fail_cnt;
        samples_owed <= kept_due.size();
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives frames of interleaved samples and register setups into the
// downscaler; checking is done by downscale_checker beside the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import nnfd_pkg::*;

    localparam int unsigned ITEM_GOAL    = 1100;    // random part stops here
    localparam int unsigned QUIET_AFTER  = 950;     // no idling past this point
    localparam int unsigned BUSY_CYCLES  = 150;     // wait that covers frame start setup
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned MAX_SEND     = 300;     // cap on samples for huge frames
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]      cfg_data;

    int unsigned fails;
    int unsigned owed;
    int unsigned items_sent;
    int unsigned cycle_count;
    bit          idle_on;

    // geometry as last written, used to size the frames
    int unsigned cur_w, cur_h, cur_c;

    always #5 aclk = ~aclk;

    nearest_neighbor_fit_downscaler_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    downscale_checker fit_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .miscompares  (fails),
        .samples_owed (owed)
    );

    // result side: random stall bursts until the quiet tail
    initial begin : result_sink
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // hard stop if the block hangs
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("nearest_neighbor_fit_downscaler_top: mismatch");
        $finish;
    end

    function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // samples in a whole frame for the current geometry
    function automatic int unsigned frame_len();
        return clip(cur_w, MAX_DIM) * clip(cur_h, MAX_DIM) * clip(cur_c, MAX_CHANNELS);
    endfunction

    // out-of-the-ordinary register value: zero, max, over max, anything, or small
    function automatic int unsigned odd_size();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return MAX_DIM;
            2:       return $urandom_range(0, 8191);
            3:       return $urandom_range(MAX_DIM + 1, 8191);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // one sample request, entered and left at a falling edge
    task automatic put_sample(input logic [SAMPLE_W-1:0] smp, input logic fs);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // frame start request followed by len-1 ordinary samples
    task automatic send_frame(input int unsigned len);
        put_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b1);
        repeat (len - 1) put_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    // hold off until every kept sample is back and frame setup is over
    task automatic settle();
        s_tvalid <= 1'b0;
        while (owed != 0) @(negedge aclk);
        repeat (BUSY_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[DIM_W-1:0];
        @(negedge aclk);
    endtask

    // write all five registers back to back, block must be idle
    task automatic setup(input int unsigned w, input int unsigned h, input int unsigned c,
                         input int unsigned bw, input int unsigned bh);
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_NUM_CHAN, c);
        write_reg(CFG_BOX_WIDTH, bw);
        write_reg(CFG_BOX_HEIGHT, bh);
        cfg_we <= 1'b0;
        cur_w = 32'(w[DIM_W-1:0]);
        cur_h = 32'(h[DIM_W-1:0]);
        cur_c = 32'(c[CH_W-1:0]);
    endtask

    initial begin : stimulus
        int unsigned full, len, extra;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SRC_WIDTH;
        cfg_data   = '0;
        aresetn    = 1'b0;
        idle_on    = 1'b1;
        items_sent = 0;
        cur_w = 1; cur_h = 1; cur_c = 3;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no frame start seen yet: both samples dropped
        put_sample(8'h5a, 1'b0);
        put_sample(8'ha5, 1'b0);
        // reset geometry 1x1, 3 channels, sample extremes, one sample past the end
        put_sample(8'h00, 1'b1);
        put_sample(8'hff, 1'b0);
        put_sample(8'h80, 1'b0);
        put_sample(8'h7f, 1'b0);

        // wide source: width fills the box, height follows
        settle();
        write_reg(CFG_UNUSED_INDEX, 'h1fff);     // unmapped index, no effect
        setup(4, 2, 1, 2, 2);
        send_frame(8);

        // tall source: height fills the box; frame cut short by the next start
        settle();
        setup(2, 4, 1, 2, 2);
        send_frame(5);

        // zero and oversized values clamp; a one-pixel-wide column scales to
        // zero width and the frame keeps nothing
        settle();
        setup(0, 8191, 7, 200, 150);
        send_frame(2);

        // random frames: mostly small clean frames, some odd setups, cut
        // frames and trailing junk
        while (items_sent < ITEM_GOAL) begin
            if (items_sent > QUIET_AFTER) idle_on = 1'b0;
            if ($urandom_range(0, 9) < 7) begin
                settle();
                if ($urandom_range(0, 9) < 8)
                    setup($urandom_range(1, 10), $urandom_range(1, 8), $urandom_range(1, 4),
                          $urandom_range(1, 12), $urandom_range(1, 10));
                else
                    setup(odd_size(), odd_size(), $urandom_range(0, 7), odd_size(), odd_size());
            end else if ($urandom_range(0, 3) == 0) begin
                settle();   // drain fully before the next frame
            end
            full  = frame_len();
            len   = full;
            extra = 0;
            case ($urandom_range(0, 9))
                0:       len   = $urandom_range(1, full > MAX_SEND ? MAX_SEND : full);
                1:       extra = $urandom_range(1, 3);
                default: ;
            endcase
            if (len > MAX_SEND) len = $urandom_range(1, MAX_SEND);
            send_frame(len);
            repeat (extra) put_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b0);
        end

        // drain and decide
        s_tvalid <= 1'b0;
        while (owed != 0) @(negedge aclk);
        repeat (BUSY_CYCLES) @(negedge aclk);
        if (fails == 0 && owed == 0)
            $display("nearest_neighbor_fit_downscaler_top: match");
        else
            $display("nearest_neighbor_fit_downscaler_top: mismatch");
        $finish;
    end

endmodule
